@@ src/idle_sleep_long_press_wake_defines.svh @@
// ----------------------------------------------------------------------------
// Idle sleep / long press wake: assertion macros
// Shared assertion wrappers for the checker of the sleep controller.
// ----------------------------------------------------------------------------
`ifndef IDLE_SLEEP_LONG_PRESS_WAKE_DEFINES_SVH
`define IDLE_SLEEP_LONG_PRESS_WAKE_DEFINES_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define ISLPW_ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Assertion on the block clock and reset, which every checker names clk and rst_n.
`define ISLPW_ASSERT(label, prop, msg) \
    `ISLPW_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

@@ src/islpw_pkg.sv @@
// ----------------------------------------------------------------------------
// Idle sleep / long press wake: package
// Phase codes, register indexes and word layout shared by RTL and checker.
// ----------------------------------------------------------------------------
package islpw_pkg;

    // Sleep phases as reported in the result word.
    typedef enum logic [2:0] {
        PH_AWAKE   = 3'd0,
        PH_RELEASE = 3'd1,
        PH_PAUSE   = 3'd2,
        PH_ARM     = 3'd3,
        PH_HOLD    = 3'd4,
        PH_SETTLE  = 3'd5
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_IDLE_LIMIT = 3'd0,
        CFG_WAKE_HOLD  = 3'd1,
        CFG_RELEASE    = 3'd2,
        CFG_ARM        = 3'd3,
        CFG_SETTLE     = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TIMER_W    = 16;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 8;

    // Bit positions in the result word.
    localparam int OUT_ASLEEP = 0;
    localparam int OUT_ENTER  = 1;
    localparam int OUT_WAKE   = 2;
    localparam int OUT_PHASE  = 3;

    // Reset values of the timing registers.
    localparam logic [CFG_DATA_W-1:0] IDLE_LIMIT_RST = 24'd0;
    localparam logic [TIMER_W-1:0]    WAKE_HOLD_RST  = 16'd1000;
    localparam logic [TIMER_W-1:0]    RELEASE_RST    = 16'd300;
    localparam logic [TIMER_W-1:0]    ARM_RST        = 16'd200;
    localparam logic [TIMER_W-1:0]    SETTLE_RST     = 16'd150;

endpackage

@@ src/idle_sleep_long_press_wake.sv @@
// ----------------------------------------------------------------------------
// Idle sleep / long press wake
// Millisecond-tick sleep controller: idle timeout or request puts the system
// to sleep, a released-then-held-then-released button sequence wakes it.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick and yields exactly one result word
// in the next cycle. The block takes a tick in every clock cycle: the single
// result register frees as it is read, so s_tready is low only while a result
// waits and m_tready is low. All state (phase, stable timer, idle counter) is
// updated in the same cycle the tick is accepted, so throughput is one tick
// per clock while the output does not stall. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and take effect on the next tick.
module idle_sleep_long_press_wake #(
    parameter int IDLE_WIDTH  = 24,
    parameter int PAUSE_TICKS = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [islpw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [islpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] button_down, [1] activity, [2] sleep_request, [7:3] zero
    input  logic [islpw_pkg::IN_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] asleep, [1] enter_pulse, [2] wake_pulse, [5:3] phase, [7:6] zero
    output logic [islpw_pkg::OUT_W-1:0]         m_tdata
);
    import islpw_pkg::*;

    localparam int CMP_W = (IDLE_WIDTH > CFG_DATA_W) ? IDLE_WIDTH : CFG_DATA_W;
    localparam logic [TIMER_W-1:0] PAUSE_LIM = TIMER_W'(PAUSE_TICKS);
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [IDLE_WIDTH-1:0] IDLE_MAX = '1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] idle_limit_reg;
    logic [TIMER_W-1:0]    wake_hold_reg;
    logic [TIMER_W-1:0]    release_reg;
    logic [TIMER_W-1:0]    arm_reg;
    logic [TIMER_W-1:0]    settle_reg;

    // Controller state
    phase_t                phase_reg, phase_next;
    logic [TIMER_W-1:0]    timer_reg, timer_next;
    logic                  armed_reg, armed_next;
    logic [IDLE_WIDTH-1:0] idle_reg, idle_next;

    // Result register
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;

    logic                  s_fire;
    logic                  btn, act, req;
    logic                  qual;
    logic [TIMER_W-1:0]    need;
    logic [TIMER_W-1:0]    st_timer;
    logic                  st_armed;
    logic                  st_done;
    logic [TIMER_W-1:0]    p_timer;
    logic                  p_done;
    logic [IDLE_WIDTH-1:0] idle_cnt;
    logic                  go_sleep;
    logic                  enter;
    logic                  wake;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign btn      = s_tdata[0];
    assign act      = s_tdata[1];
    assign req      = s_tdata[2];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Stable timer: first qualifying sample loads zero, later ones count up.
    always_comb
    begin
        qual = (phase_reg == PH_HOLD) ? btn : !btn;
        case (phase_reg)
            PH_RELEASE: need = release_reg;
            PH_ARM:     need = arm_reg;
            PH_HOLD:    need = wake_hold_reg;
            PH_SETTLE:  need = settle_reg;
            default:    need = TIMER_MAX;
        endcase
        if (!qual)
        begin
            st_timer = '0;
            st_armed = 1'b0;
        end
        else if (!armed_reg)
        begin
            st_timer = '0;
            st_armed = 1'b1;
        end
        else
        begin
            st_timer = (timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
            st_armed = 1'b1;
        end
        st_done = qual && (st_timer >= need);

        // The pause counts every tick, whatever the button does.
        p_timer = (timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
        p_done  = (p_timer >= PAUSE_LIM);

        if (act)
            idle_cnt = '0;
        else if (idle_reg != IDLE_MAX)
            idle_cnt = idle_reg + 1'b1;
        else
            idle_cnt = idle_reg;
        go_sleep = req || ((idle_limit_reg != '0) &&
                           (CMP_W'(idle_cnt) >= CMP_W'(idle_limit_reg)));
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        armed_next = armed_reg;
        idle_next  = idle_reg;
        case (phase_reg)
            PH_RELEASE, PH_ARM, PH_HOLD, PH_SETTLE:
            begin
                timer_next = st_timer;
                armed_next = st_armed;
                if (st_done)
                begin
                    timer_next = '0;
                    armed_next = 1'b0;
                    case (phase_reg)
                        PH_RELEASE: phase_next = PH_PAUSE;
                        PH_ARM:     phase_next = PH_HOLD;
                        PH_HOLD:    phase_next = PH_SETTLE;
                        default:
                        begin
                            phase_next = PH_AWAKE;
                            idle_next  = '0;
                        end
                    endcase
                end
            end
            PH_PAUSE:
            begin
                timer_next = p_timer;
                if (p_done)
                begin
                    phase_next = PH_ARM;
                    timer_next = '0;
                    armed_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_AWAKE;
                idle_next  = idle_cnt;
                if (go_sleep)
                begin
                    phase_next = PH_RELEASE;
                    timer_next = '0;
                    armed_next = 1'b0;
                    idle_next  = '0;
                end
            end
        endcase
    end

    // Pulses
    always_comb
    begin
        enter = 1'b0;
        wake  = 1'b0;
        case (phase_reg)
            PH_RELEASE, PH_PAUSE, PH_ARM, PH_HOLD: ;
            PH_SETTLE: wake  = st_done;
            default:   enter = go_sleep;
        endcase
    end

    // Result word
    always_comb
    begin
        m_data_next                    = '0;
        m_data_next[OUT_ASLEEP]        = (phase_next != PH_AWAKE);
        m_data_next[OUT_ENTER]         = enter;
        m_data_next[OUT_WAKE]          = wake;
        m_data_next[OUT_PHASE +: 3]    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            wake_hold_reg  <= WAKE_HOLD_RST;
            release_reg    <= RELEASE_RST;
            arm_reg        <= ARM_RST;
            settle_reg     <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data;
                CFG_WAKE_HOLD:  wake_hold_reg  <= cfg_data[TIMER_W-1:0];
                CFG_RELEASE:    release_reg    <= cfg_data[TIMER_W-1:0];
                CFG_ARM:        arm_reg        <= cfg_data[TIMER_W-1:0];
                CFG_SETTLE:     settle_reg     <= cfg_data[TIMER_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_AWAKE;
            timer_reg <= '0;
            armed_reg <= 1'b0;
            idle_reg  <= '0;
        end
        else if (s_fire)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            armed_reg <= armed_next;
            idle_reg  <= idle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_tready)
            m_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            m_data_reg <= m_data_next;
    end

endmodule

@@ src/islpw_checker.sv @@
// ----------------------------------------------------------------------------
// Idle sleep / long press wake: port checker
// Watches the stream ports of the sleep controller and flags bad results.
// ----------------------------------------------------------------------------
`include "idle_sleep_long_press_wake_defines.svh"

module islpw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [islpw_pkg::IN_W-1:0]          s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [islpw_pkg::OUT_W-1:0]         m_tdata
);
    import islpw_pkg::*;

    logic [2:0] ph;
    logic       in_fire;

    assign ph      = m_tdata[OUT_PHASE +: 3];
    assign in_fire = s_tvalid && s_tready;

    // A stalled result word holds until it is taken.
    `ISLPW_ASSERT(a_out_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result word changed while stalled")

    // Every accepted tick yields a result on the next cycle.
    `ISLPW_ASSERT(a_one_result, in_fire |=> m_tvalid,
        "accepted tick produced no result")

    // The asleep flag agrees with the reported phase.
    `ISLPW_ASSERT(a_asleep_phase,
        m_tvalid |-> (m_tdata[OUT_ASLEEP] == (ph != PH_AWAKE)),
        "asleep flag disagrees with phase")

    // Sleep entry lands in the release phase, wake lands in awake.
    `ISLPW_ASSERT(a_enter_phase, m_tvalid && m_tdata[OUT_ENTER] |-> ph == PH_RELEASE,
        "enter pulse outside release phase")

    `ISLPW_ASSERT(a_wake_phase,
        m_tvalid && m_tdata[OUT_WAKE] |-> ph == PH_AWAKE && !m_tdata[OUT_ENTER],
        "wake pulse with wrong phase")

endmodule

bind idle_sleep_long_press_wake islpw_checker u_islpw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb_idle_sleep_long_press_wake.sv @@
// ----------------------------------------------------------------------------
// Sleep controller testbench
// Streams millisecond ticks into the idle sleep / long press wake block and
// checks every status word against a cycle-free model of the phase machine.
// The run covers directed corner cases, full sleep and wake sessions with
// random timing registers, stalls on both sides and a stretch of noise.
// ----------------------------------------------------------------------------
module tb_idle_sleep_long_press_wake;
    timeunit 1ns;
    timeprecision 1ps;

    import islpw_pkg::*;

    localparam int PAUSE_LEN  = 100;
    localparam int LONG_STALL = 400;
    localparam int LIMIT_NS   = 5_000_000;
    localparam int BTN_BIT    = 0;
    localparam int ACT_BIT    = 1;
    localparam int REQ_BIT    = 2;

    typedef struct packed {
        logic   asleep;
        logic   enter;
        logic   wake;
        phase_t phase;
    } status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [0] button_down, [1] activity, [2] sleep_request, [7:3] zero
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] asleep, [1] enter_pulse, [2] wake_pulse, [5:3] phase, [7:6] zero
    logic [OUT_W-1:0]      m_tdata;

    // Model copy of the registers and the phase machine.
    logic [CFG_DATA_W-1:0] lim_cfg     = IDLE_LIMIT_RST;
    logic [TIMER_W-1:0]    hold_cfg    = WAKE_HOLD_RST;
    logic [TIMER_W-1:0]    release_cfg = RELEASE_RST;
    logic [TIMER_W-1:0]    arm_cfg     = ARM_RST;
    logic [TIMER_W-1:0]    settle_cfg  = SETTLE_RST;
    phase_t                cur_phase   = PH_AWAKE;
    logic [TIMER_W-1:0]    stab_timer  = '0;
    logic                  stab_run    = 1'b0;
    logic [23:0]           idle_ticks  = '0;

    logic [IN_W-1:0] tick_q[$];
    status_t         pending_status[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int n_enters = 0;
    int n_wakes = 0;
    int n_backpressure = 0;
    int n_settings = 1;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_left = 0;
    logic long_stall_req = 1'b0;
    logic long_stall_done = 1'b0;

    idle_sleep_long_press_wake uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic bit rbit();
        return bit'($urandom_range(1, 0));
    endfunction

    function automatic void clear_stable();
        stab_timer = '0;
        stab_run   = 1'b0;
    endfunction

    // The stable timer starts at zero on the first qualifying sample and the
    // phase ends once it reaches the required time.
    function automatic bit stable_done(bit qual, logic [TIMER_W-1:0] need);
        if (!qual) begin
            clear_stable();
            return 1'b0;
        end
        if (!stab_run) begin
            stab_run   = 1'b1;
            stab_timer = '0;
        end else if (stab_timer != '1) begin
            stab_timer = stab_timer + 1'b1;
        end
        return stab_timer >= need;
    endfunction

    function automatic status_t advance_sleep_fsm(logic [IN_W-1:0] word);
        status_t r;
        bit      btn;
        bit      act;
        bit      req;
        btn = word[BTN_BIT];
        act = word[ACT_BIT];
        req = word[REQ_BIT];
        r.enter = 1'b0;
        r.wake  = 1'b0;
        case (cur_phase)
            PH_RELEASE:
                if (stable_done(!btn, release_cfg)) begin
                    cur_phase = PH_PAUSE;
                    clear_stable();
                end
            PH_PAUSE:
            begin
                // The pause counts every tick, whatever the button does.
                if (stab_timer != '1)
                    stab_timer = stab_timer + 1'b1;
                if (stab_timer >= PAUSE_LEN) begin
                    cur_phase = PH_ARM;
                    clear_stable();
                end
            end
            PH_ARM:
                if (stable_done(!btn, arm_cfg)) begin
                    cur_phase = PH_HOLD;
                    clear_stable();
                end
            PH_HOLD:
                if (stable_done(btn, hold_cfg)) begin
                    cur_phase = PH_SETTLE;
                    clear_stable();
                end
            PH_SETTLE:
                if (stable_done(!btn, settle_cfg)) begin
                    cur_phase  = PH_AWAKE;
                    clear_stable();
                    idle_ticks = '0;
                    r.wake     = 1'b1;
                end
            default:
            begin
                cur_phase = PH_AWAKE;
                if (act)
                    idle_ticks = '0;
                else if (idle_ticks != '1)
                    idle_ticks = idle_ticks + 1'b1;
                if (req || (lim_cfg != '0 && idle_ticks >= lim_cfg)) begin
                    cur_phase  = PH_RELEASE;
                    clear_stable();
                    idle_ticks = '0;
                    r.enter    = 1'b1;
                end
            end
        endcase
        r.asleep = (cur_phase != PH_AWAKE);
        r.phase  = cur_phase;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (n_errors < 50)
            $display("%0t mismatch on %s: expected %0d, got %0d",
                     $realtime, what, want, got);
        n_errors++;
    endtask

    // Sender: offers the next tick once the current word is taken.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tick_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that fills the block.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_tready        <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every accepted tick, checks every accepted status word.
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_status.size() == 0) begin
                    report_mismatch("status word with no tick pending", 0, int'(m_tdata));
                end else begin
                    want = pending_status.pop_front();
                    if (m_tdata[OUT_ASLEEP] !== want.asleep)
                        report_mismatch("asleep", int'(want.asleep),
                                        int'(m_tdata[OUT_ASLEEP]));
                    if (m_tdata[OUT_ENTER] !== want.enter)
                        report_mismatch("enter_pulse", int'(want.enter),
                                        int'(m_tdata[OUT_ENTER]));
                    if (m_tdata[OUT_WAKE] !== want.wake)
                        report_mismatch("wake_pulse", int'(want.wake),
                                        int'(m_tdata[OUT_WAKE]));
                    if (m_tdata[OUT_PHASE +: 3] !== want.phase)
                        report_mismatch("phase", int'(want.phase),
                                        int'(m_tdata[OUT_PHASE +: 3]));
                end
                if (m_tdata[OUT_ENTER] === 1'b1)
                    n_enters++;
                if (m_tdata[OUT_WAKE] === 1'b1)
                    n_wakes++;
            end
            if (s_tvalid && s_tready) begin
                pending_status.push_back(advance_sleep_fsm(s_tdata));
                n_accepted++;
            end
            if (s_tvalid && !s_tready)
                n_backpressure++;
        end
    end

    task automatic push_tick(bit btn, bit act, bit req);
        logic [IN_W-1:0] w;
        w          = '0;
        w[BTN_BIT] = btn;
        w[ACT_BIT] = act;
        w[REQ_BIT] = req;
        tick_q.push_back(w);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_IDLE_LIMIT: lim_cfg     = val;
            CFG_WAKE_HOLD:  hold_cfg    = val[TIMER_W-1:0];
            CFG_RELEASE:    release_cfg = val[TIMER_W-1:0];
            CFG_ARM:        arm_cfg     = val[TIMER_W-1:0];
            CFG_SETTLE:     settle_cfg  = val[TIMER_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic random_timing(int tmax, int hmax);
        case ($urandom_range(2, 0))
            0: write_reg(CFG_IDLE_LIMIT, '0);
            1: write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'($urandom_range(20, 3)));
            default: write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'($urandom_range(60, 30)));
        endcase
        write_reg(CFG_WAKE_HOLD, CFG_DATA_W'($urandom_range(hmax, 1)));
        write_reg(CFG_RELEASE, CFG_DATA_W'($urandom_range(tmax, 1)));
        write_reg(CFG_ARM, CFG_DATA_W'($urandom_range(tmax, 1)));
        write_reg(CFG_SETTLE, CFG_DATA_W'($urandom_range(tmax, 1)));
        n_settings++;
    endtask

    // A run at one button level that just completes a phase, sometimes after
    // a short run that gets broken by the opposite level.
    task automatic push_stable(logic [TIMER_W-1:0] need, bit level);
        if ($urandom_range(2, 0) == 0) begin
            repeat ($urandom_range(need, 1)) push_tick(level, rbit(), rbit());
            repeat ($urandom_range(2, 1)) push_tick(!level, rbit(), rbit());
        end
        repeat (int'(need) + 1) push_tick(level, rbit(), rbit());
    endtask

    // One full session: awake stretch, sleep by request or timeout, then the
    // release, pause, arm, hold and settle phases back to awake.
    task automatic add_sleep_cycle(bit asleep_now);
        bit quiet;
        if (!asleep_now) begin
            // Off the timeout path, activity only goes missing where it cannot trip the idle limit.
            quiet = (lim_cfg == '0 || lim_cfg > 25);
            push_tick(rbit(), 1'b1, 1'b0);
            if (lim_cfg != '0 && lim_cfg <= 40 && rbit()) begin
                repeat (lim_cfg) push_tick(rbit(), 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(18, 0)) push_tick(rbit(), quiet ? rbit() : 1'b1, 1'b0);
                push_tick(rbit(), rbit(), 1'b1);
            end
            // The user is often still holding the button.
            repeat ($urandom_range(4, 0)) push_tick(1'b1, rbit(), rbit());
        end
        push_stable(release_cfg, 1'b0);
        repeat (PAUSE_LEN) push_tick(rbit(), rbit(), rbit());
        push_stable(arm_cfg, 1'b0);
        push_stable(hold_cfg, 1'b1);
        push_stable(settle_cfg, 1'b0);
        repeat ($urandom_range(4, 1)) push_tick(rbit(), 1'b1, 1'b0);
    endtask

    initial
    begin
        #(LIMIT_NS * 1ns);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        bit btn_level;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: no auto sleep, request enters with a long release.
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        wait_drained();

        // Shortest timings; finish the release that is in progress.
        write_reg(CFG_IDLE_LIMIT, 24'd3);
        write_reg(CFG_WAKE_HOLD, 24'd1);
        write_reg(CFG_RELEASE, 24'd1);
        write_reg(CFG_ARM, 24'd1);
        write_reg(CFG_SETTLE, 24'd1);
        push_tick(1'b0, 1'b0, 1'b0);
        repeat (PAUSE_LEN) push_tick(rbit(), rbit(), rbit());
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b1);
        // Awake again: three idle ticks reach the limit.
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        add_sleep_cycle(1'b1);
        wait_drained();

        // Lowering the limit below an idle count already reached sleeps at once.
        write_reg(CFG_IDLE_LIMIT, '0);
        repeat (6) push_tick(1'b0, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_IDLE_LIMIT, 24'd2);
        push_tick(1'b0, 1'b0, 1'b0);
        add_sleep_cycle(1'b1);
        wait_drained();

        set_idling(0, 0);
        repeat (3)
        begin
            random_timing(8, 12);
            add_sleep_cycle(1'b0);
            wait_drained();
        end

        set_idling(79, 0);
        repeat (2)
        begin
            random_timing(8, 12);
            add_sleep_cycle(1'b0);
            wait_drained();
        end

        set_idling(0, 79);
        repeat (2)
        begin
            random_timing(8, 12);
            add_sleep_cycle(1'b0);
            wait_drained();
        end

        set_idling(17, 17);
        repeat (3)
        begin
            random_timing(8, 12);
            add_sleep_cycle(1'b0);
            if (!long_stall_done) begin
                @(posedge clk);
                long_stall_req <= 1'b1;
            end
            wait_drained();
        end

        // Largest register values: the limit is never reached and the release
        // phase cannot finish within the run.
        set_idling(0, 0);
        write_reg(CFG_IDLE_LIMIT, 24'hFFFFFF);
        write_reg(CFG_WAKE_HOLD, 24'h00FFFF);
        write_reg(CFG_RELEASE, 24'h00FFFF);
        write_reg(CFG_ARM, 24'h00FFFF);
        write_reg(CFG_SETTLE, 24'h00FFFF);
        n_settings++;
        repeat (30) push_tick(rbit(), 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b1);
        repeat (40) push_tick(1'b0, rbit(), rbit());
        push_tick(1'b1, 1'b0, 1'b0);
        wait_drained();

        // Leave sleep under short timings, then a stretch of noise.
        random_timing(2, 2);
        write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'($urandom_range(3, 1)));
        set_idling(17, 17);
        add_sleep_cycle(1'b1);
        btn_level = 1'b0;
        repeat (200)
        begin
            if ($urandom_range(9, 0) < 3)
                btn_level = !btn_level;
            push_tick(btn_level, $urandom_range(9, 0) < 3, $urandom_range(19, 0) == 0);
        end
        wait_drained();

        $display("Covered %0d ticks under %0d timing settings: %0d sleep entries, %0d wakes.",
                 n_accepted, n_settings, n_enters, n_wakes);
        $display("Tick input was held off by a full output for %0d cycles.", n_backpressure);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
